### sv/ptc_pkg.sv
// Package: shared types and constants for the pressure/temperature compensation core.
package ptc_pkg;
  localparam int TrimW   = 48;
  localparam int CfgIdxW = 2;
  localparam int RawW    = 20;
  localparam int DivSteps = 64;

  typedef enum logic [1:0] {
    REG_TEMP  = 2'd0,
    REG_PFIRST = 2'd1,
    REG_PMID  = 2'd2,
    REG_PLAST = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [RawW-1:0] raw_temperature;
    logic [RawW-1:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] fine_temperature;
    logic signed [31:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
  } out_item_t;

  // 16-bit trim word sign-extended to 64 bits
  function automatic logic [63:0] trim_s(input logic [15:0] w);
    trim_s = {{48{w[15]}}, w};
  endfunction
endpackage

### sv/ptc_if.sv
// Interface: valid/ready channel carrying one payload.
interface ptc_in_if (input logic clk);
  logic valid;
  logic ready;
  ptc_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ptc_out_if (input logic clk);
  logic valid;
  logic ready;
  ptc_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/ptc_div.sv
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating toward zero.
module ptc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  input  logic [95:0] side_in,
  output logic        out_valid,
  output logic [63:0] quotient,
  output logic [95:0] side_out
);
  localparam int N = ptc_pkg::DivSteps;
  logic        v   [N+1];
  logic [63:0] rem [N+1];
  logic [63:0] quo [N+1];
  logic [63:0] dv  [N+1];
  logic        neg [N+1];
  logic [95:0] sd  [N+1];

  always_comb begin
    v[0]   = in_valid;
    dv[0]  = divisor[63] ? (64'd0 - divisor) : divisor;
    quo[0] = dividend[63] ? (64'd0 - dividend) : dividend;
    rem[0] = '0;
    neg[0] = dividend[63] ^ divisor[63];
    sd[0]  = side_in;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [64:0] sh;
    logic [64:0] df;
    always_comb begin
      sh = {rem[i], quo[i][63]};
      df = sh - {1'b0, dv[i]};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (adv) begin
        v[i+1] <= v[i];
      end
      if (adv) begin
        rem[i+1] <= df[64] ? sh[63:0] : df[63:0];
        quo[i+1] <= {quo[i][62:0], ~df[64]};
        dv[i+1]  <= dv[i];
        neg[i+1] <= neg[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign out_valid = v[N];
  assign quotient  = neg[N] ? (64'd0 - quo[N]) : quo[N];
  assign side_out  = sd[N];
endmodule

### sv/pressure_temperature_compensation_core.sv
// Top level: pipelined integer compensation of raw temperature and pressure samples.
// The core accepts one transaction per clock and returns one result per transaction,
// in order, once it has passed seven register stages of temperature and
// trim arithmetic, a 64-stage restoring divider that retires one quotient bit per stage,
// three stages of pressure correction and the output register. Each 64-bit product is
// built from three 32x32 slices in one stage. A stall on the output freezes the whole
// pipeline and holds off the input until the waiting result is taken; with the output
// ready, a new transaction can enter on every clock.
module pressure_temperature_compensation_core (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [ptc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [ptc_pkg::TrimW-1:0] cfg_data,
  ptc_in_if.sink   in_ch,
  ptc_out_if.source out_ch
);
  logic [47:0] trim_t, trim_p1, trim_p2, trim_p3;

  always_ff @(posedge clk) begin
    if (rst) begin
      trim_t <= '0; trim_p1 <= '0; trim_p2 <= '0; trim_p3 <= '0;
    end else if (cfg_we) begin
      unique case (ptc_pkg::cfg_reg_t'(cfg_index))
        ptc_pkg::REG_TEMP:   trim_t  <= cfg_data;
        ptc_pkg::REG_PFIRST: trim_p1 <= cfg_data;
        ptc_pkg::REG_PMID:   trim_p2 <= cfg_data;
        ptc_pkg::REG_PLAST:  trim_p3 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = {16'd0, trim_t[15:0]};
  assign t2 = {{16{trim_t[31]}}, trim_t[31:16]};
  assign t3 = {{16{trim_t[47]}}, trim_t[47:32]};
  assign p1 = {48'd0, trim_p1[15:0]};
  assign p2 = ptc_pkg::trim_s(trim_p1[31:16]);
  assign p3 = ptc_pkg::trim_s(trim_p1[47:32]);
  assign p4 = ptc_pkg::trim_s(trim_p2[15:0]);
  assign p5 = ptc_pkg::trim_s(trim_p2[31:16]);
  assign p6 = ptc_pkg::trim_s(trim_p2[47:32]);
  assign p7 = ptc_pkg::trim_s(trim_p3[15:0]);
  assign p8 = ptc_pkg::trim_s(trim_p3[31:16]);
  assign p9 = ptc_pkg::trim_s(trim_p3[47:32]);

  // 64x64 low product from 32-bit slices
  function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] ll, lh, hl;
    ll = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh = {32'd0, a[31:0]} * {32'd0, b[63:32]};
    hl = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    mul64 = ll + {lh[31:0] + hl[31:0], 32'd0};
  endfunction

  logic adv;
  logic ov;
  logic div_ov;
  assign adv = !ov || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: temperature products
  logic v1;
  logic [19:0] s1_p;
  logic [31:0] s1_a2, s1_dd;
  logic [31:0] a_c, d_c;
  assign a_c = {15'd0, in_ch.data.raw_temperature[19:3]} - {t1[30:0], 1'b0};
  assign d_c = {16'd0, in_ch.data.raw_temperature[19:4]} - t1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0; else if (adv) v1 <= in_ch.valid;
    if (adv) begin
      s1_p  <= in_ch.data.raw_pressure;
      s1_a2 <= a_c * t2;
      s1_dd <= d_c * d_c;
    end
  end

  // stage 2
  logic v2;
  logic [19:0] s2_p;
  logic [31:0] s2_tv1, s2_m;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0; else if (adv) v2 <= v1;
    if (adv) begin
      s2_p   <= s1_p;
      s2_tv1 <= 32'($signed(s1_a2) >>> 11);
      s2_m   <= 32'($signed(s1_dd) >>> 12) * t3;
    end
  end

  // stage 3: fine temperature
  logic v3;
  logic [19:0] s3_p;
  logic [31:0] s3_fine;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0; else if (adv) v3 <= v2;
    if (adv) begin
      s3_p    <= s2_p;
      s3_fine <= s2_tv1 + 32'($signed(s2_m) >>> 14);
    end
  end

  logic [31:0] centi_c;
  assign centi_c = 32'($signed(s3_fine * 32'd5 + 32'd128) >>> 8);

  // stage 4: v1 and its square
  logic v4;
  logic [19:0] s4_p;
  logic [31:0] s4_fine, s4_centi;
  logic [63:0] s4_v1, s4_sq;
  logic [63:0] v1_c;
  assign v1_c = {{32{s3_fine[31]}}, s3_fine} - 64'd128000;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0; else if (adv) v4 <= v3;
    if (adv) begin
      s4_p <= s3_p; s4_fine <= s3_fine; s4_centi <= centi_c;
      s4_v1 <= v1_c;
      s4_sq <= mul64(v1_c, v1_c);
    end
  end

  // stage 5: products with trims
  logic v5;
  logic [19:0] s5_p;
  logic [31:0] s5_fine, s5_centi;
  logic [63:0] s5_a, s5_b, s5_c, s5_d;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0; else if (adv) v5 <= v4;
    if (adv) begin
      s5_p <= s4_p; s5_fine <= s4_fine; s5_centi <= s4_centi;
      s5_a <= mul64(s4_sq, p6);
      s5_b <= mul64(s4_v1, p5);
      s5_c <= mul64(s4_sq, p3);
      s5_d <= mul64(s4_v1, p2);
    end
  end

  // stage 6: v2 and var1 sums
  logic v6;
  logic [19:0] s6_p;
  logic [31:0] s6_fine, s6_centi;
  logic [63:0] s6_v2, s6_x;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0; else if (adv) v6 <= v5;
    if (adv) begin
      s6_p <= s5_p; s6_fine <= s5_fine; s6_centi <= s5_centi;
      s6_v2 <= s5_a + {s5_b[46:0], 17'd0} + {p4[28:0], 35'd0};
      s6_x  <= (64'd1 << 47) + 64'($signed(s5_c) >>> 8) + {s5_d[51:0], 12'd0};
    end
  end

  // stage 7: divisor and dividend base
  logic v7;
  logic [31:0] s7_fine, s7_centi;
  logic [63:0] s7_div, s7_num;
  logic [63:0] pp_c, num_c;
  assign pp_c  = 64'd1048576 - {44'd0, s6_p};
  assign num_c = {pp_c[32:0], 31'd0} - s6_v2;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0; else if (adv) v7 <= v6;
    if (adv) begin
      s7_fine <= s6_fine; s7_centi <= s6_centi;
      s7_div <= 64'($signed(mul64(s6_x, p1)) >>> 33);
      s7_num <= mul64(num_c, 64'd3125);
    end
  end

  logic [63:0] q;
  logic [95:0] side_q;
  ptc_div u_div (
    .clk(clk), .rst(rst), .adv(adv), .in_valid(v7),
    .dividend(s7_num), .divisor(s7_div),
    .side_in({s7_fine, s7_centi, 31'd0, (s7_div == 64'd0)}),
    .out_valid(div_ov), .quotient(q), .side_out(side_q)
  );

  // stage 8: p8*p product and scaled p
  logic v8;
  logic [95:0] s8_sd;
  logic [63:0] s8_p, s8_ps, s8_w2;
  logic [63:0] ps_c;
  assign ps_c = 64'($signed(q) >>> 13);
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0; else if (adv) v8 <= div_ov;
    if (adv) begin
      s8_sd <= side_q; s8_p <= q; s8_ps <= ps_c;
      s8_w2 <= mul64(p8, q);
    end
  end

  logic v9;
  logic [95:0] s9_sd;
  logic [63:0] s9_p, s9_ps, s9_t, s9_w2;
  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0; else if (adv) v9 <= v8;
    if (adv) begin
      s9_sd <= s8_sd; s9_p <= s8_p; s9_ps <= s8_ps; s9_w2 <= s8_w2;
      s9_t <= mul64(p9, s8_ps);
    end
  end

  logic v10;
  logic [95:0] s10_sd;
  logic [63:0] s10_p, s10_w1, s10_w2;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0; else if (adv) v10 <= v9;
    if (adv) begin
      s10_sd <= s9_sd; s10_p <= s9_p;
      s10_w1 <= 64'($signed(mul64(s9_t, s9_ps)) >>> 25);
      s10_w2 <= 64'($signed(s9_w2) >>> 19);
    end
  end

  // output register
  logic [63:0] pf_c;
  assign pf_c = 64'($signed(s10_p + s10_w1 + s10_w2) >>> 8) + {p7[59:0], 4'd0};
  always_ff @(posedge clk) begin
    if (rst) ov <= 1'b0; else if (adv) ov <= v10;
    if (adv) begin
      out_ch.data.fine_temperature  <= s10_sd[95:64];
      out_ch.data.temperature_centi <= s10_sd[63:32];
      out_ch.data.pressure_q24_8    <= s10_sd[0] ? 32'd0 : pf_c[31:0];
    end
  end
  assign out_ch.valid = ov;
endmodule

### sv/ptc_checker.sv
// Checker: port-level properties of the compensation core, bound to the top level.
module ptc_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_fine
);
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("input stalled with empty output");
  a_ready_follows_out: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready) else $error("input stalled while output drains");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_fine))
    else $error("stalled result changed");
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result after reset");
endmodule

bind pressure_temperature_compensation_core ptc_checker u_ptc_checker (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_fine(out_ch.data.fine_temperature)
);
